// File: design/ssq_pkg.sv
package ssq_pkg;

   // Number of cells in the chain, i.e. the queue capacity.
   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int OCC_W = 5;

   typedef enum logic [1:0] {
      CMD_ENQ = 2'd0,
      CMD_DEQ = 2'd1,
      CMD_CLR = 2'd2
   } cmd_type;

   // Per-cycle command broadcast to every cell.
   typedef struct packed {
      logic enq;   // insert the broadcast word, queue not full
      logic deq;   // shift toward the head, queue not empty
   } ssq_ctl_type;

endpackage

// File: design/ssq_cell.sv
module ssq_cell
   import ssq_pkg::*;
(
   input  logic                     clock,
   input  ssq_ctl_type              ctl,
   input  logic signed [DATA_W-1:0] new_key,
   input  logic signed [DATA_W-1:0] new_value,
   input  logic                     occupied,
   input  logic                     left_keep,
   input  logic signed [DATA_W-1:0] left_key,
   input  logic signed [DATA_W-1:0] left_value,
   input  logic signed [DATA_W-1:0] right_key,
   input  logic signed [DATA_W-1:0] right_value,
   output logic                     keep,
   output logic signed [DATA_W-1:0] key,
   output logic signed [DATA_W-1:0] value
);

   logic signed [DATA_W-1:0] key_ff, key_in;
   logic signed [DATA_W-1:0] value_ff, value_in;

   // Stay in place when this entry sorts at or ahead of the new key.
   assign keep = occupied && (key_ff <= new_key);

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (ctl.enq && !keep) begin
         if (left_keep) begin
            key_in   = new_key;
            value_in = new_value;
         end else begin
            key_in   = left_key;
            value_in = left_value;
         end
      end else if (ctl.deq) begin
         key_in   = right_key;
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign key   = key_ff;
   assign value = value_ff;

endmodule

// File: design/stable_sorted_priority_queue.sv
// A result word appears in the cycle after its request word is taken.
// Throughput: one request word per cycle unless stalled by a held result;
// every cell decides its move locally from its own compare and its left neighbor's.
// Reset: synchronous, active high; clears the entry count and the result valid.
// Cell contents are not reset; cells beyond the count are never read.
module stable_sorted_priority_queue
   import ssq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_cmd,
   input  logic signed [DATA_W-1:0] req_item_value,
   input  logic signed [DATA_W-1:0] req_item_key,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_out_value,
   output logic                     rsp_out_valid,
   output logic                     rsp_empty_error,
   output logic                     rsp_full_drop,
   output logic                     rsp_now_empty,
   output logic [OCC_W-1:0]         rsp_occupancy
);

   // Entry count; cell i holds a live entry when i < count.
   logic [CNT_W-1:0] count_ff, count_in;

   // Result register, parts the request side from the result side.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] out_value_ff, out_value_in;
   logic                     out_valid_ff, out_valid_in;
   logic                     empty_error_ff, empty_error_in;
   logic                     full_drop_ff, full_drop_in;
   logic                     now_empty_ff, now_empty_in;
   logic [OCC_W-1:0]         occupancy_ff, occupancy_in;

   logic        req_fire;
   logic        is_full;
   logic        is_empty;
   ssq_ctl_type ctl;

   logic signed [DATA_W-1:0] key_vec   [DEPTH];
   logic signed [DATA_W-1:0] value_vec [DEPTH];
   logic [DEPTH-1:0]         keep_vec;

   // Take a new word whenever the result register is free or draining.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;

   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);

   // Decode the command and work out the result for this word.
   always_comb begin
      ctl            = '0;
      count_in       = count_ff;
      out_value_in   = '0;
      out_valid_in   = 1'b0;
      empty_error_in = 1'b0;
      full_drop_in   = 1'b0;
      if (req_fire) begin
         unique case (req_cmd)
            CMD_ENQ: begin
               if (is_full) begin
                  full_drop_in = 1'b1;
               end else begin
                  ctl.enq  = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_DEQ: begin
               if (is_empty) begin
                  empty_error_in = 1'b1;
               end else begin
                  ctl.deq      = 1'b1;
                  out_value_in = value_vec[0];
                  out_valid_in = 1'b1;
                  count_in     = count_ff - 1'b1;
               end
            end
            CMD_CLR: begin
               count_in = '0;
            end
            default: begin
               // Unused code: no operation, no outcome flag set.
               count_in = count_ff;
            end
         endcase
      end
      now_empty_in = (count_in == '0);
      occupancy_in = OCC_W'(count_in);
   end

   // Hold the result until it is taken; load a new one with each word.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // The chain: each cell holds one entry, sorted ascending from cell 0.
   // Enqueue: cells that keep their entry stay, the first other cell loads the
   // new word, the rest advance one place from their left neighbor.
   // Dequeue: every cell loads from its right neighbor.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                     occupied;
      logic                     left_keep;
      logic signed [DATA_W-1:0] left_key;
      logic signed [DATA_W-1:0] left_value;
      logic signed [DATA_W-1:0] right_key;
      logic signed [DATA_W-1:0] right_value;

      assign occupied = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_keep  = 1'b1;
         assign left_key   = '0;
         assign left_value = '0;
      end else begin : g_body
         assign left_keep  = keep_vec[i-1];
         assign left_key   = key_vec[i-1];
         assign left_value = value_vec[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_key   = '0;
         assign right_value = '0;
      end else begin : g_inner
         assign right_key   = key_vec[i+1];
         assign right_value = value_vec[i+1];
      end

      ssq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .new_key     (req_item_key),
         .new_value   (req_item_value),
         .occupied    (occupied),
         .left_keep   (left_keep),
         .left_key    (left_key),
         .left_value  (left_value),
         .right_key   (right_key),
         .right_value (right_value),
         .keep        (keep_vec[i]),
         .key         (key_vec[i]),
         .value       (value_vec[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         out_value_ff   <= out_value_in;
         out_valid_ff   <= out_valid_in;
         empty_error_ff <= empty_error_in;
         full_drop_ff   <= full_drop_in;
         now_empty_ff   <= now_empty_in;
         occupancy_ff   <= occupancy_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_value   = out_value_ff;
   assign rsp_out_valid   = out_valid_ff;
   assign rsp_empty_error = empty_error_ff;
   assign rsp_full_drop   = full_drop_ff;
   assign rsp_now_empty   = now_empty_ff;
   assign rsp_occupancy   = occupancy_ff;

   // Count never exceeds the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above capacity");

   // Cells that keep their entry form a prefix of the chain (sorted order).
   a_keep_prefix: assert property (@(posedge clock) disable iff (reset)
      (keep_vec & (keep_vec + 1'b1)) == '0)
      else $error("keep flags not a prefix, chain out of order");

   // A successful dequeue lowers the count by exactly one.
   a_deq_count: assert property (@(posedge clock) disable iff (reset)
      ctl.deq |=> count_ff == $past(count_ff) - 1'b1)
      else $error("dequeue did not lower the count by one");

   // At most one outcome flag per result word.
   a_flags_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({out_valid_ff, empty_error_ff, full_drop_ff}))
      else $error("more than one outcome flag set");

endmodule

// File: bench/tb_stable_sorted_priority_queue.sv
module tb_stable_sorted_priority_queue;
   import ssq_pkg::*;

   // Code with no operation behind it; the block must answer it with a
   // plain status word and leave its contents alone.
   localparam logic [1:0] CMD_NONE = 2'd3;

   // Cycles with no handshake on either side before the run is declared hung.
   localparam int HANG_LIMIT = 2000;
   localparam int RANDOM_WORDS = 600;

   // One result word, laid out field by field as the block reports it.
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     taken;
      logic                     empty_err;
      logic                     dropped;
      logic                     now_empty;
      logic [OCC_W-1:0]         occ;
   } result_type;

   // One request word; known marks a row whose answer is typed in by hand.
   typedef struct packed {
      logic [1:0]               cmd;
      logic signed [DATA_W-1:0] val;
      logic signed [DATA_W-1:0] key;
      logic                     known;
      result_type               exp;
   } req_word_type;

   localparam result_type R_DEQ_EMPTY = '{value: '0, taken: 1'b0, empty_err: 1'b1,
                                          dropped: 1'b0, now_empty: 1'b1, occ: '0};
   localparam result_type R_CLEARED   = '{value: '0, taken: 1'b0, empty_err: 1'b0,
                                          dropped: 1'b0, now_empty: 1'b1, occ: '0};
   localparam result_type R_PREDICT   = '0;

   localparam logic signed [DATA_W-1:0] KMIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] KMAX = 32'sh7fff_ffff;

   // Directed words: empty-queue errors and no-ops first, then extreme keys and
   // values with ties at zero and at the top key (arrival order must hold),
   // a full drain past empty, and a clear of a non-empty queue.
   localparam int DIR_ROWS = 23;
   localparam req_word_type DIR_TABLE [0:DIR_ROWS-1] = '{
      '{CMD_DEQ,  32'sh0,         32'sh0,         1'b1, R_DEQ_EMPTY},
      '{CMD_NONE, 32'shffff_ffff, 32'shffff_ffff, 1'b1, R_CLEARED},
      '{CMD_CLR,  32'shffff_ffff, 32'sh0,         1'b1, R_CLEARED},
      '{CMD_ENQ,  KMIN,           KMAX,           1'b0, R_PREDICT},
      '{CMD_ENQ,  KMAX,           KMIN,           1'b0, R_PREDICT},
      '{CMD_ENQ,  32'sh1,         32'sh0,         1'b0, R_PREDICT},
      '{CMD_ENQ,  32'sh2,         32'sh0,         1'b0, R_PREDICT},
      '{CMD_ENQ,  32'shffff_ffff, 32'shffff_ffff, 1'b0, R_PREDICT},
      '{CMD_ENQ,  32'sh3,         32'sh0,         1'b0, R_PREDICT},
      '{CMD_ENQ,  32'sh4,         KMAX,           1'b0, R_PREDICT},
      '{CMD_NONE, 32'shaaaa_5555, 32'sh5555_aaaa, 1'b0, R_PREDICT},
      '{CMD_DEQ,  32'sh5555_aaaa, 32'shaaaa_5555, 1'b0, R_PREDICT},
      '{CMD_DEQ,  32'sh0,         32'sh0,         1'b0, R_PREDICT},
      '{CMD_DEQ,  32'sh0,         32'sh0,         1'b0, R_PREDICT},
      '{CMD_DEQ,  32'sh0,         32'sh0,         1'b0, R_PREDICT},
      '{CMD_DEQ,  32'sh0,         32'sh0,         1'b0, R_PREDICT},
      '{CMD_DEQ,  32'sh0,         32'sh0,         1'b0, R_PREDICT},
      '{CMD_DEQ,  32'sh0,         32'sh0,         1'b0, R_PREDICT},
      '{CMD_DEQ,  32'sh0,         32'sh0,         1'b1, R_DEQ_EMPTY},
      '{CMD_ENQ,  32'sh5,         KMIN,           1'b0, R_PREDICT},
      '{CMD_ENQ,  32'sh6,         KMIN,           1'b0, R_PREDICT},
      '{CMD_CLR,  32'sh0,         32'sh0,         1'b1, R_CLEARED},
      '{CMD_DEQ,  32'sh0,         32'sh0,         1'b1, R_DEQ_EMPTY}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_cmd = CMD_NONE;
   logic signed [DATA_W-1:0] req_item_value = '0;
   logic signed [DATA_W-1:0] req_item_key = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_out_value;
   logic                     rsp_out_valid;
   logic                     rsp_empty_error;
   logic                     rsp_full_drop;
   logic                     rsp_now_empty;
   logic [OCC_W-1:0]         rsp_occupancy;

   stable_sorted_priority_queue dut (.*);

   always #1 clock = ~clock;

   // Our own copy of the queue: sorted keys and values, and the fill count.
   logic signed [DATA_W-1:0] held_key [DEPTH];
   logic signed [DATA_W-1:0] held_val [DEPTH];
   int                       held_cnt = 0;

   req_word_type word_q [$];           // every request word, directed rows first
   result_type   pending_results [$];  // results owed by the block, oldest first

   int next_idx = 0, cur_idx = 0, words_taken = 0, results_seen = 0;
   int send_wait = 0, stall_left = 0, calm_req = 0, calm_rsp = 0;
   int errors = 0, idle_cycles = 0;
   int n_enq = 0, n_drop = 0, n_deq = 0, n_deq_empty = 0, n_clr = 0, n_nop = 0;

   // Apply one command to the local queue and return the word it must produce.
   // Insert after every key that is equal or smaller, so ties keep arrival order.
   function automatic result_type pq_apply(req_word_type w);
      result_type               r;
      logic signed [DATA_W-1:0] k;
      int                       pos;
      r = '0;
      k = w.key;
      if (w.cmd == CMD_ENQ) begin
         n_enq++;
         if (held_cnt >= DEPTH) begin
            r.dropped = 1'b1;
            n_drop++;
         end else begin
            pos = 0;
            while (pos < held_cnt && held_key[pos] <= k) pos++;
            for (int i = held_cnt; i > pos; i--) begin
               held_key[i] = held_key[i-1];
               held_val[i] = held_val[i-1];
            end
            held_key[pos] = k;
            held_val[pos] = w.val;
            held_cnt++;
         end
      end else if (w.cmd == CMD_DEQ) begin
         n_deq++;
         if (held_cnt == 0) begin
            r.empty_err = 1'b1;
            n_deq_empty++;
         end else begin
            r.value = held_val[0];
            r.taken = 1'b1;
            for (int i = 1; i < held_cnt; i++) begin
               held_key[i-1] = held_key[i];
               held_val[i-1] = held_val[i];
            end
            held_cnt--;
         end
      end else if (w.cmd == CMD_CLR) begin
         n_clr++;
         held_cnt = 0;
      end else begin
         n_nop++;
      end
      r.now_empty = (held_cnt == 0);
      r.occ = OCC_W'(held_cnt);
      return r;
   endfunction

   // Mostly short pauses, a few long ones; now and then open a calm stretch
   // in which the side never idles.
   function automatic int next_pause(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) calm = $urandom_range(20, 60);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Keys: full range, a narrow band around zero, the extremes, or a small
   // positive band; the narrow bands force plenty of ties.
   function automatic logic signed [DATA_W-1:0] rand_key();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 8)) - 4;
         2: begin
            case ($urandom_range(0, 3))
               0: return KMIN;
               1: return KMAX;
               2: return -1;
               default: return 0;
            endcase
         end
         default: return $urandom_range(0, 15);
      endcase
   endfunction

   function automatic req_word_type make_word(logic [1:0] cmd);
      req_word_type w;
      w = '0;
      w.cmd = cmd;
      w.val = $urandom;
      w.key = (cmd == CMD_ENQ) ? rand_key() : $signed($urandom);
      return w;
   endfunction

   task automatic report_bad(string why, result_type want, result_type got);
      errors++;
      if (errors <= 10) begin
         $display("%s (result %0d)", why, results_seen);
         $display("  want value=%h taken=%b err=%b drop=%b empty=%b occ=%0d",
                  want.value, want.taken, want.empty_err, want.dropped,
                  want.now_empty, want.occ);
         $display("  got  value=%h taken=%b err=%b drop=%b empty=%b occ=%0d",
                  got.value, got.taken, got.empty_err, got.dropped,
                  got.now_empty, got.occ);
      end
   endtask

   // Build the whole stimulus list: directed rows, then random bursts. Fill
   // bursts can run past capacity to hit the full drop, drain bursts can run past
   // empty, mixed stretches interleave, and clears and no-ops come as noise.
   task automatic build_stimulus();
      int counted, n, r;
      logic [1:0] c;
      counted = 0;
      for (int i = 0; i < DIR_ROWS; i++) word_q.push_back(DIR_TABLE[i]);
      while (counted < RANDOM_WORDS) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            n = $urandom_range(1, DEPTH + 4);
            repeat (n) word_q.push_back(make_word(CMD_ENQ));
            counted += n;
         end else if (r < 70) begin
            n = $urandom_range(1, DEPTH + 3);
            repeat (n) word_q.push_back(make_word(CMD_DEQ));
            counted += n;
         end else if (r < 92) begin
            n = $urandom_range(1, 20);
            repeat (n) begin
               r = $urandom_range(0, 99);
               c = (r < 50) ? CMD_ENQ : (r < 95) ? CMD_DEQ : (r < 98) ? CMD_CLR : CMD_NONE;
               word_q.push_back(make_word(c));
               if (c != CMD_NONE) counted++;
            end
         end else if (r < 97) begin
            word_q.push_back(make_word(CMD_CLR));
            counted++;
         end else begin
            word_q.push_back(make_word(CMD_NONE));
         end
      end
   endtask

   // Request side: on a handshake, run the predictor and queue the answer;
   // then either hold valid low for a pause or present the next word.
   always @(posedge clock) begin
      result_type want;
      logic       fire;
      fire = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (fire) begin
            want = pq_apply(word_q[cur_idx]);
            if (word_q[cur_idx].known) want = word_q[cur_idx].exp;
            pending_results.push_back(want);
            words_taken++;
         end
         if (!req_valid || fire) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (next_idx < word_q.size()) begin
               req_valid <= 1'b1;
               req_cmd <= word_q[next_idx].cmd;
               req_item_value <= word_q[next_idx].val;
               req_item_key <= word_q[next_idx].key;
               cur_idx = next_idx;
               next_idx++;
               send_wait = next_pause(calm_req);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result side: check each accepted word against the oldest expectation,
   // and stall at random, always dropping the stall before raising it again.
   always @(posedge clock) begin
      result_type got, want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{value: rsp_out_value, taken: rsp_out_valid,
                    empty_err: rsp_empty_error, dropped: rsp_full_drop,
                    now_empty: rsp_now_empty, occ: rsp_occupancy};
            results_seen++;
            if (pending_results.size() == 0) begin
               report_bad("result word with nothing expected", '0, got);
            end else begin
               want = pending_results.pop_front();
               if (got !== want) report_bad("result word mismatch", want, got);
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = next_pause(calm_rsp);
         end
      end
   end

   // Hang detector: any handshake on either side resets the count.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= HANG_LIMIT) begin
            $display("hang: no handshake for %0d cycles, %0d results still owed",
                     idle_cycles, pending_results.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      build_stimulus();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // Wait for every word to go in and every answer to come back, then
      // let the clock run on so that any stray result shows.
      while (words_taken < word_q.size() || pending_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Sent %0d words: %0d enqueues (%0d dropped full), %0d dequeues (%0d empty),",
               words_taken, n_enq, n_drop, n_deq, n_deq_empty);
      $display("  %0d clears, %0d no-ops; %0d results checked, %0d bad",
               n_clr, n_nop, results_seen, errors);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
